FILE: rtl/dr2alu_pkg.sv
// Shared types and constants for the dyadic root-2 ring ALU.
package dr2alu_pkg;

  localparam int ACTION_WIDTH = 3;
  localparam int LDE_WIDTH    = 9;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_EQ  = 3'd3,
    ACT_LDE = 3'd4
  } action_t;

endpackage

FILE: rtl/dr2alu_if.sv
// Valid/ready channel interfaces for operand items and result items.
interface dr2alu_in_if
  import dr2alu_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int EXP_WIDTH  = 8
);
  logic                         valid;
  logic                         ready;
  logic [ACTION_WIDTH-1:0]      action;
  logic signed [DATA_WIDTH-1:0] first_int;
  logic signed [DATA_WIDTH-1:0] first_root;
  logic [EXP_WIDTH-1:0]         first_exp;
  logic signed [DATA_WIDTH-1:0] second_int;
  logic signed [DATA_WIDTH-1:0] second_root;
  logic [EXP_WIDTH-1:0]         second_exp;

  modport source (
    output valid, action, first_int, first_root, first_exp,
           second_int, second_root, second_exp,
    input  ready
  );
  modport sink (
    input  valid, action, first_int, first_root, first_exp,
           second_int, second_root, second_exp,
    output ready
  );
endinterface

interface dr2alu_out_if
  import dr2alu_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int EXP_WIDTH  = 8
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_int;
  logic signed [DATA_WIDTH-1:0] res_root;
  logic [EXP_WIDTH-1:0]         res_exp;
  logic                         is_equal;
  logic [LDE_WIDTH-1:0]         lde_value;
  logic                         overflow;

  modport source (
    output valid, res_int, res_root, res_exp, is_equal, lde_value, overflow,
    input  ready
  );
  modport sink (
    input  valid, res_int, res_root, res_exp, is_equal, lde_value, overflow,
    output ready
  );
endinterface

FILE: rtl/dr2alu_tz.sv
// Trailing-zero counter with an all-zero flag.
module dr2alu_tz
  import dr2alu_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0]         value,
  output logic [$clog2(WIDTH+1)-1:0] count,
  output logic                     zero
);
  localparam int CW = $clog2(WIDTH + 1);

  always_comb begin
    count = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (value[i]) count = CW'(i);
    end
    zero = (value == '0);
  end
endmodule

FILE: rtl/dyadic_root2_ring_alu_top.sv
// Top level of the dyadic root-2 ring ALU: three-stage pipeline.
//
// Operates on numbers (a + b*sqrt2)/2^c. Operand items arrive on src, a
// valid/ready channel; each transfer yields exactly one result item on dst.
// Actions: add, subtract, multiply (all reduced to lowest exponent), equal
// compare of raw fields, and least denominator exponent of the first operand.
//
// Pipeline: stage 1 aligns operands and forms the four full products, stage 2
// sums and checks overflow (LDE finishes here from trailing-zero counts),
// stage 3 reduces through trailing-zero counts and is the output register.
// Throughput is one item per cycle while dst.ready holds, set by the
// per-stage handshake. The DATA_WIDTH x DATA_WIDTH multipliers of stage 1
// set the clock period.
//
// Each stage carries its own valid bit and moves when the next stage is free,
// so bubbles are squeezed out. When dst stalls, items pile up in the stages
// and src.ready drops once all three are full; nothing is lost or repeated.
// Synchronous reset clears the valid bits only; the first item may be sent
// in the cycle after rst falls.
module dyadic_root2_ring_alu_top
  import dr2alu_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int EXP_WIDTH  = 8
) (
  input  logic clk,
  input  logic rst,
  dr2alu_in_if.sink    src,
  dr2alu_out_if.source dst
);
  localparam int DW  = DATA_WIDTH;
  localparam int EW  = EXP_WIDTH;
  localparam int PW  = 2 * DW;
  localparam int CW  = $clog2(DW + 1);
  localparam int E1  = EW + 1;
  localparam int XA  = (E1 > CW + 1) ? E1 : CW + 1;
  localparam int XW  = (XA > LDE_WIDTH + 1) ? XA : LDE_WIDTH + 1;
  localparam int TW  = (CW > E1) ? CW : E1;

  function automatic logic [DW:0] shl_f(logic signed [DW-1:0] v, logic [EW-1:0] d);
    logic signed [DW-1:0] r;
    logic                 o;
    if (int'(d) >= DW) begin
      r = '0;
      o = (v != '0);
    end else begin
      r = v <<< d;
      o = ((r >>> d) != v);
    end
    return {o, r};
  endfunction

  function automatic logic fits(logic signed [PW-1:0] p);
    return p[PW-1:DW-1] == {(DW + 1){p[DW-1]}};
  endfunction

  // handshake
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  assign rdy3 = !v3 || dst.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign src.ready = rdy1;
  assign dst.valid = v3;

  // stage 1
  logic [ACTION_WIDTH-1:0] s1_act;
  logic signed [DW-1:0]    s1_sa1, s1_sb1, s1_sa2, s1_sb2;
  logic                    s1_shov;
  logic [EW-1:0]           s1_k;
  logic [E1-1:0]           s1_csum;
  logic signed [PW-1:0]    s1_paa, s1_pbb, s1_pab, s1_pba;
  logic                    s1_eq;
  logic [EW-1:0]           s1_c1;
  logic [CW-1:0]           s1_ta, s1_tb;
  logic                    s1_za, s1_zb;

  logic [EW-1:0] k;
  logic [DW:0]   sh_a1, sh_b1, sh_a2, sh_b2;
  logic [CW-1:0] ta_in, tb_in;
  logic          za_in, zb_in;

  dr2alu_tz #(.WIDTH(DW)) u_tz_la (.value(src.first_int),  .count(ta_in), .zero(za_in));
  dr2alu_tz #(.WIDTH(DW)) u_tz_lb (.value(src.first_root), .count(tb_in), .zero(zb_in));

  always_comb begin
    k     = (src.first_exp > src.second_exp) ? src.first_exp : src.second_exp;
    sh_a1 = shl_f(src.first_int,   k - src.first_exp);
    sh_b1 = shl_f(src.first_root,  k - src.first_exp);
    sh_a2 = shl_f(src.second_int,  k - src.second_exp);
    sh_b2 = shl_f(src.second_root, k - src.second_exp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= src.valid;
    end
    if (rdy1 && src.valid) begin
      s1_act  <= src.action;
      s1_sa1  <= sh_a1[DW-1:0];
      s1_sb1  <= sh_b1[DW-1:0];
      s1_sa2  <= sh_a2[DW-1:0];
      s1_sb2  <= sh_b2[DW-1:0];
      s1_shov <= sh_a1[DW] | sh_b1[DW] | sh_a2[DW] | sh_b2[DW];
      s1_k    <= k;
      s1_csum <= E1'(src.first_exp) + E1'(src.second_exp);
      s1_paa  <= src.first_int  * src.second_int;
      s1_pbb  <= src.first_root * src.second_root;
      s1_pab  <= src.first_int  * src.second_root;
      s1_pba  <= src.first_root * src.second_int;
      s1_eq   <= (src.first_int == src.second_int) && (src.first_root == src.second_root)
                 && (src.first_exp == src.second_exp);
      s1_c1   <= src.first_exp;
      s1_ta   <= ta_in;
      s1_tb   <= tb_in;
      s1_za   <= za_in;
      s1_zb   <= zb_in;
    end
  end

  // stage 2
  logic signed [DW-1:0]  s2_a, s2_b;
  logic [E1-1:0]         s2_c;
  logic                  s2_eq, s2_ov;
  logic [LDE_WIDTH-1:0]  s2_lde;

  logic signed [DW-1:0]  ra, rb, waa, wbb, wab, wba, bb2;
  logic [E1-1:0]         rc;
  logic                  req, rov;
  logic [LDE_WIDTH-1:0]  rlde;
  logic [XW-1:0]         e2, n2, lfull;

  always_comb begin
    ra    = '0;
    rb    = '0;
    rc    = '0;
    req   = 1'b0;
    rov   = 1'b0;
    rlde  = '0;
    waa   = s1_paa[DW-1:0];
    wbb   = s1_pbb[DW-1:0];
    wab   = s1_pab[DW-1:0];
    wba   = s1_pba[DW-1:0];
    bb2   = wbb <<< 1;
    e2    = '0;
    n2    = '0;
    lfull = '0;
    unique case (s1_act)
      ACT_ADD: begin
        ra  = s1_sa1 + s1_sa2;
        rb  = s1_sb1 + s1_sb2;
        rc  = E1'(s1_k);
        rov = s1_shov
              || (s1_sa1[DW-1] == s1_sa2[DW-1] && ra[DW-1] != s1_sa1[DW-1])
              || (s1_sb1[DW-1] == s1_sb2[DW-1] && rb[DW-1] != s1_sb1[DW-1]);
      end
      ACT_SUB: begin
        ra  = s1_sa1 - s1_sa2;
        rb  = s1_sb1 - s1_sb2;
        rc  = E1'(s1_k);
        rov = s1_shov
              || (s1_sa1[DW-1] != s1_sa2[DW-1] && ra[DW-1] != s1_sa1[DW-1])
              || (s1_sb1[DW-1] != s1_sb2[DW-1] && rb[DW-1] != s1_sb1[DW-1]);
      end
      ACT_MUL: begin
        ra  = waa + bb2;
        rb  = wab + wba;
        rc  = s1_csum;
        rov = !fits(s1_paa) || !fits(s1_pbb) || !fits(s1_pab) || !fits(s1_pba)
              || (wbb[DW-1] != wbb[DW-2])
              || (waa[DW-1] == bb2[DW-1] && ra[DW-1] != waa[DW-1])
              || (wab[DW-1] == wba[DW-1] && rb[DW-1] != wab[DW-1]);
      end
      ACT_EQ: begin
        req = s1_eq;
      end
      ACT_LDE: begin
        e2 = (s1_za && s1_zb) ? '0 : XW'({s1_c1, 1'b0});
        if (!s1_za && (s1_zb || s1_ta <= s1_tb)) n2 = XW'({s1_ta, 1'b0});
        else                                      n2 = XW'({s1_tb, 1'b1});
        lfull = (e2 > n2) ? e2 - n2 : '0;
        rlde  = lfull[LDE_WIDTH-1:0];
        rov   = |lfull[XW-1:LDE_WIDTH];
      end
      default: begin
        ra = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      s2_a   <= ra;
      s2_b   <= rb;
      s2_c   <= rc;
      s2_eq  <= req;
      s2_ov  <= rov;
      s2_lde <= rlde;
    end
  end

  // stage 3: reduction
  logic [CW-1:0] tza, tzb;
  logic          zra, zrb;
  logic [TW-1:0] t;
  logic [E1-1:0] cnew;

  dr2alu_tz #(.WIDTH(DW)) u_tz_ra (.value(s2_a), .count(tza), .zero(zra));
  dr2alu_tz #(.WIDTH(DW)) u_tz_rb (.value(s2_b), .count(tzb), .zero(zrb));

  always_comb begin
    priority if (zra && zrb) t = TW'(s2_c);
    else if (zra)            t = TW'(tzb);
    else if (zrb)            t = TW'(tza);
    else                     t = (tza < tzb) ? TW'(tza) : TW'(tzb);
    if (TW'(s2_c) < t) t = TW'(s2_c);
    cnew = s2_c - E1'(t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      dst.res_int   <= s2_a >>> t;
      dst.res_root  <= s2_b >>> t;
      dst.res_exp   <= cnew[EW-1:0];
      dst.is_equal  <= s2_eq;
      dst.lde_value <= s2_lde;
      dst.overflow  <= s2_ov | cnew[EW];
    end
  end
endmodule
